// ===== rtl/core/helc_pkg.sv =====
// Package for the heater energy limit controller.
// Holds shared widths, reset values, status and register codes.
// No dependencies.
package helc_pkg;

    localparam int PERIOD_TICKS_DEF     = 100;
    localparam int TICKS_PER_SECOND_DEF = 10000;

    localparam int ADC_BITS = 10;
    localparam int ADC_W    = 10;
    localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((1 << ADC_BITS) - 1);

    localparam int BAT_W    = 13;
    localparam int CFG_W    = 18;
    localparam int CFG_AW   = 3;
    localparam int ENERGY_W = 32;
    localparam int TICK_W   = 20;
    localparam int TPS_W    = 17;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam int MV_PER_V     = 1000;
    localparam int Q_FRAC       = 13;
    localparam int TARGET_SCALE = 100;
    localparam int RATIO_SCALE  = 10;

    // Serial divider geometry.
    localparam int DIV_W = 56;
    localparam int REM_W = 24;
    localparam int CNT_W = 6;

    localparam logic [12:0] REF_MV_RST   = 13'd1200;
    localparam logic [17:0] RES_RST      = 18'd8192;
    localparam logic [7:0]  TARGET_RST   = 8'd5;
    localparam logic [5:0]  MAX_SEC_RST  = 6'd8;
    localparam logic [9:0]  SHORT_RST    = 10'd5;
    localparam logic [9:0]  OPEN_RST     = 10'd200;
    localparam logic [12:0] LOW_BAT_RST  = 13'd3300;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_HEAT    = 3'd1,
        ST_TIMEOUT = 3'd2,
        ST_LOWBAT  = 3'd3,
        ST_SHORT   = 3'd4,
        ST_OPEN    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        REG_REFERENCE_MV   = 3'd0,
        REG_HEATER_RES     = 3'd1,
        REG_TARGET_POWER   = 3'd2,
        REG_MAX_HEAT_SEC   = 3'd3,
        REG_SHORT_RATIO    = 3'd4,
        REG_OPEN_RATIO     = 3'd5,
        REG_LOW_BATTERY_MV = 3'd6
    } t_cfg_idx;

endpackage

// ===== rtl/core/heater_energy_limit_controller.sv =====
// A request with no power calculation goes straight to the output state; one with power
// runs the divider for heater power and, when the ratio is due, the short/open ratio.
// A shared bit-serial divider gives one quotient bit per cycle (23 + 25 + 28 + 37 + 54 steps
// at most, each division adding a load and a final step). A request is taken only while idle,
// after the last result has entered the output register, where it waits. Reset is synchronous,
// active low, and restores all but the datapath and output data registers.
module heater_energy_limit_controller #(
    parameter int PERIOD_TICKS     = helc_pkg::PERIOD_TICKS_DEF,
    parameter int TICKS_PER_SECOND = helc_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_puff_active,
    input  logic [helc_pkg::ADC_W-1:0]      i_heater_sample,
    input  logic [helc_pkg::ADC_W-1:0]      i_reference_sample,
    input  logic [helc_pkg::BAT_W-1:0]      i_battery_mv,
    input  logic                            i_battery_valid,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_heater_drive,
    output logic [2:0]                      o_status,
    output logic [helc_pkg::ENERGY_W-1:0]   o_energy,
    output logic                            o_power_enable,
    input  logic                            i_cfg_we,
    input  logic [helc_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [helc_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam logic [6:0]                  PERIOD_P = PERIOD_TICKS[6:0];
    localparam logic [helc_pkg::TPS_W-1:0]  TPS_P    = TICKS_PER_SECOND[helc_pkg::TPS_W-1:0];

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        OP_REF   = 3'd0,
        OP_THIRD = 3'd1,
        OP_RATIO = 3'd2,
        OP_VOLT  = 3'd3,
        OP_RES   = 3'd4
    } t_op;

    // Configuration registers.
    logic [12:0] r_ref_mv;
    logic [17:0] r_res;
    logic [7:0]  r_target;
    logic [5:0]  r_max_sec;
    logic [9:0]  r_short;
    logic [9:0]  r_open;
    logic [12:0] r_low_bat;

    // Block state.
    helc_pkg::t_status                  r_status;
    logic [6:0]                         r_phase;
    logic [helc_pkg::TICK_W-1:0]        r_ticks;
    logic                               r_running;
    logic                               r_started;
    logic                               r_enable;
    logic                               r_drive;
    logic [helc_pkg::ENERGY_W-1:0]      r_energy;
    logic [helc_pkg::BAT_W-1:0]         r_battery;

    // Sequencer and datapath.
    t_state                             r_state;
    t_op                                r_op;
    logic                               r_do_ratio;
    logic                               r_wrap;
    logic [helc_pkg::ADC_W-1:0]         r_hs;
    logic [helc_pkg::ADC_W-1:0]         r_rs;
    logic [22:0]                        r_q1;
    logic [23:0]                        r_mv;
    logic [23:0]                        r_d;
    logic [27:0]                        r_ratio;
    logic [26:0]                        r_v;
    logic [53:0]                        r_vv;
    logic [31:0]                        r_p;
    logic [helc_pkg::DIV_W-1:0]         r_a;
    logic [helc_pkg::REM_W-1:0]         r_rem;
    logic [helc_pkg::REM_W-1:0]         r_dsr;
    logic [helc_pkg::CNT_W-1:0]         r_cnt;

    // Output register.
    logic                               r_ov;
    logic                               r_o_drive;
    logic [2:0]                         r_o_status;
    logic [helc_pkg::ENERGY_W-1:0]      r_o_energy;
    logic                               r_o_enable;

    logic accept;
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Per-tick control update, taken at the accepting edge.
    logic [22:0]                   lim_raw;
    logic [helc_pkg::TICK_W-1:0]   lim;
    helc_pkg::t_status             n_status;
    logic [6:0]                    n_phase;
    logic [helc_pkg::TICK_W-1:0]   n_ticks;
    logic                          n_running;
    logic                          n_started;
    logic                          n_enable;
    logic                          n_drive;
    logic [helc_pkg::ENERGY_W-1:0] n_energy;
    logic [helc_pkg::BAT_W-1:0]    n_battery;
    logic                          n_pow;
    logic                          n_ratio;
    logic                          n_wrap;
    logic                          n_work;

    assign lim_raw = 23'(r_max_sec) * 23'(TPS_P);
    assign lim     = (lim_raw > 23'(helc_pkg::TICK_MAX)) ? helc_pkg::TICK_MAX
                                                         : lim_raw[helc_pkg::TICK_W-1:0];

    always_comb begin
        n_status  = r_status;
        n_phase   = r_phase;
        n_ticks   = r_ticks;
        n_running = r_running;
        n_started = r_started;
        n_enable  = r_enable;
        n_drive   = r_drive;
        n_energy  = r_energy;
        n_battery = r_battery;
        n_pow     = 1'b0;
        n_ratio   = 1'b0;
        n_wrap    = 1'b0;
        if (r_running) begin
            if (n_ticks != helc_pkg::TICK_MAX) begin
                n_ticks = n_ticks + 1'b1;
            end
            if (n_ticks >= lim) begin
                n_status  = helc_pkg::ST_TIMEOUT;
                n_running = 1'b0;
                n_ticks   = '0;
            end
        end
        n_work = i_puff_active &&
                 (n_status == helc_pkg::ST_IDLE || n_status == helc_pkg::ST_HEAT);
        if (n_work) begin
            n_phase = r_phase + 7'd1;
            if (n_phase == 7'd1) begin
                n_drive = 1'b0;
                if (i_battery_valid) begin
                    n_battery = i_battery_mv;
                end
                if (n_battery < r_low_bat) begin
                    n_status = helc_pkg::ST_LOWBAT;
                    n_enable = 1'b0;
                end else begin
                    n_enable = 1'b1;
                    if (!r_started) begin
                        n_started = 1'b1;
                        n_ticks   = '0;
                        n_running = 1'b1;
                        n_status  = helc_pkg::ST_HEAT;
                    end
                end
            end else if (n_phase >= 7'd2 && n_phase < 7'd5) begin
                n_drive = 1'b1;
                n_pow   = 1'b1;
            end else begin
                if (r_enable) begin
                    n_pow   = 1'b1;
                    n_ratio = 1'b1;
                end else if (i_battery_valid) begin
                    n_battery = i_battery_mv;
                end
                if (n_phase == PERIOD_P) begin
                    n_wrap  = 1'b1;
                    n_phase = '0;
                    n_drive = 1'b0;
                    // With a power calculation pending, the energy clears at the end.
                    if (!r_enable) begin
                        n_energy = '0;
                    end
                end
            end
        end else begin
            n_drive = 1'b0;
            if (!i_puff_active) begin
                n_status  = helc_pkg::ST_IDLE;
                n_started = 1'b0;
                n_phase   = '0;
                n_ticks   = '0;
                n_running = 1'b0;
            end
        end
    end

    // Divider operand selection; the dividend is left aligned in r_a.
    logic [helc_pkg::DIV_W-1:0] ld_a;
    logic [helc_pkg::REM_W-1:0] ld_dsr;
    logic [helc_pkg::CNT_W-1:0] ld_cnt;
    logic [22:0]                prod_ref;
    logic [27:0]                mv_x10;

    assign prod_ref = 23'(r_hs) * 23'(r_ref_mv);
    assign mv_x10   = 28'(r_mv) * 28'(helc_pkg::RATIO_SCALE);

    always_comb begin
        case (r_op)
            OP_REF: begin
                ld_a   = {prod_ref, 33'd0};
                ld_dsr = (r_rs == '0) ? 24'd1 : 24'(r_rs);
                ld_cnt = 6'd23;
            end
            OP_THIRD: begin
                ld_a   = {r_q1, 2'b00, 31'd0};
                ld_dsr = 24'd3;
                ld_cnt = 6'd25;
            end
            OP_RATIO: begin
                ld_a   = {mv_x10, 28'd0};
                ld_dsr = r_d;
                ld_cnt = 6'd28;
            end
            OP_VOLT: begin
                ld_a   = {r_mv, helc_pkg::Q_FRAC'(0), 19'd0};
                ld_dsr = 24'(helc_pkg::MV_PER_V);
                ld_cnt = 6'd37;
            end
            OP_RES: begin
                ld_a   = {r_vv, 2'b00};
                ld_dsr = (r_res == '0) ? 24'd1 : 24'(r_res);
                ld_cnt = 6'd54;
            end
            default: begin
                ld_a   = '0;
                ld_dsr = 24'd1;
                ld_cnt = '0;
            end
        endcase
    end

    // One restoring division step.
    logic [helc_pkg::REM_W:0]   div_trial;
    logic                       div_ge;
    logic [helc_pkg::REM_W:0]   div_sub;

    assign div_trial = {r_rem, r_a[helc_pkg::DIV_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_dsr});
    assign div_sub   = div_trial - {1'b0, r_dsr};

    // Results of the final step.
    logic [23:0]                   mv_res;
    logic [23:0]                   d_res;
    logic [32:0]                   sum;
    logic [helc_pkg::ENERGY_W-1:0] e_new;
    logic [14:0]                   tgt_scaled;
    logic [helc_pkg::ENERGY_W-1:0] tgt_limit;
    logic                          fin_off;

    assign mv_res     = r_a[23:0];
    assign d_res      = ({11'd0, r_battery} > mv_res) ? ({11'd0, r_battery} - mv_res)
                                                      : (mv_res - {11'd0, r_battery});
    assign sum        = 33'(r_energy) + 33'(r_p);
    assign e_new      = sum[32] ? '1 : sum[31:0];
    assign tgt_scaled = 15'(r_target) * 15'(helc_pkg::TARGET_SCALE);
    assign tgt_limit  = 32'({tgt_scaled, helc_pkg::Q_FRAC'(0)});
    // The heater switches off on a fault, on reaching the target or at the period end.
    assign fin_off    = r_wrap || (r_do_ratio && ((r_ratio <= 28'(r_short)) ||
                                                  (r_ratio >= 28'(r_open)) ||
                                                  (e_new >= tgt_limit)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mv  <= helc_pkg::REF_MV_RST;
            r_res     <= helc_pkg::RES_RST;
            r_target  <= helc_pkg::TARGET_RST;
            r_max_sec <= helc_pkg::MAX_SEC_RST;
            r_short   <= helc_pkg::SHORT_RST;
            r_open    <= helc_pkg::OPEN_RST;
            r_low_bat <= helc_pkg::LOW_BAT_RST;
        end else if (i_cfg_we) begin
            unique case (helc_pkg::t_cfg_idx'(i_cfg_addr))
                helc_pkg::REG_REFERENCE_MV:   r_ref_mv  <= i_cfg_data[12:0];
                helc_pkg::REG_HEATER_RES:     r_res     <= i_cfg_data[17:0];
                helc_pkg::REG_TARGET_POWER:   r_target  <= i_cfg_data[7:0];
                helc_pkg::REG_MAX_HEAT_SEC:   r_max_sec <= i_cfg_data[5:0];
                helc_pkg::REG_SHORT_RATIO:    r_short   <= i_cfg_data[9:0];
                helc_pkg::REG_OPEN_RATIO:     r_open    <= i_cfg_data[9:0];
                helc_pkg::REG_LOW_BATTERY_MV: r_low_bat <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= helc_pkg::ST_IDLE;
            r_phase    <= '0;
            r_ticks    <= '0;
            r_running  <= 1'b0;
            r_started  <= 1'b0;
            r_enable   <= 1'b1;
            r_drive    <= 1'b0;
            r_energy   <= '0;
            r_battery  <= '0;
            r_state    <= S_IDLE;
            r_op       <= OP_REF;
            r_do_ratio <= 1'b0;
            r_wrap     <= 1'b0;
            r_cnt      <= '0;
            r_ov       <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && (!r_ov || !i_out_stall)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status   <= n_status;
                        r_phase    <= n_phase;
                        r_ticks    <= n_ticks;
                        r_running  <= n_running;
                        r_started  <= n_started;
                        r_enable   <= n_enable;
                        r_drive    <= n_drive;
                        r_energy   <= n_energy;
                        r_battery  <= n_battery;
                        r_do_ratio <= n_ratio;
                        r_wrap     <= n_wrap;
                        r_hs       <= i_heater_sample & helc_pkg::ADC_MASK;
                        r_rs       <= i_reference_sample & helc_pkg::ADC_MASK;
                        r_op       <= OP_REF;
                        r_state    <= n_pow ? S_LOAD : S_OUT;
                    end
                end
                S_LOAD: begin
                    r_a     <= ld_a;
                    r_dsr   <= ld_dsr;
                    r_rem   <= '0;
                    r_cnt   <= ld_cnt;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt != '0) begin
                        r_a   <= {r_a[helc_pkg::DIV_W-2:0], div_ge};
                        r_rem <= div_ge ? div_sub[helc_pkg::REM_W-1:0]
                                        : div_trial[helc_pkg::REM_W-1:0];
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        case (r_op)
                            OP_REF: begin
                                r_q1    <= r_a[22:0];
                                r_op    <= OP_THIRD;
                                r_state <= S_LOAD;
                            end
                            OP_THIRD: begin
                                r_mv    <= mv_res;
                                r_d     <= d_res;
                                r_state <= S_LOAD;
                                if (r_do_ratio && d_res != '0) begin
                                    r_op <= OP_RATIO;
                                end else begin
                                    // No voltage across the battery gap reads as open.
                                    r_ratio <= 28'(r_open);
                                    r_op    <= OP_VOLT;
                                end
                            end
                            OP_RATIO: begin
                                r_ratio <= r_a[27:0];
                                r_op    <= OP_VOLT;
                                r_state <= S_LOAD;
                            end
                            OP_VOLT: begin
                                r_v     <= r_a[26:0];
                                r_state <= S_MUL;
                            end
                            OP_RES: begin
                                r_p     <= (|r_a[helc_pkg::DIV_W-1:32]) ? '1 : r_a[31:0];
                                r_state <= S_FIN;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_MUL: begin
                    r_vv    <= 54'(r_v) * 54'(r_v);
                    r_op    <= OP_RES;
                    r_state <= S_LOAD;
                end
                S_FIN: begin
                    r_energy <= r_wrap ? '0 : e_new;
                    if (r_do_ratio) begin
                        if (r_ratio <= 28'(r_short)) begin
                            r_status <= helc_pkg::ST_SHORT;
                        end else if (r_ratio >= 28'(r_open)) begin
                            r_status <= helc_pkg::ST_OPEN;
                        end else begin
                            r_status <= helc_pkg::ST_HEAT;
                        end
                        if (e_new >= tgt_limit) begin
                            r_enable <= 1'b0;
                        end
                    end
                    if (fin_off) begin
                        r_drive <= 1'b0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_ov || !i_out_stall)) begin
            r_o_drive  <= r_drive;
            r_o_status <= r_status;
            r_o_energy <= r_energy;
            r_o_enable <= r_enable;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_heater_drive = r_o_drive;
    assign o_status       = r_o_status;
    assign o_energy       = r_o_energy;
    assign o_power_enable = r_o_enable;

endmodule

// ===== rtl/core/helc_checker.sv =====
// Port-level checks for the heater energy limit controller.
// Depends on helc_pkg; bound to heater_energy_limit_controller below.
module helc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic                            o_heater_drive,
    input logic [2:0]                      o_status,
    input logic [helc_pkg::ENERGY_W-1:0]   o_energy,
    input logic                            o_power_enable
);

    // A pending result stays put while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
        $stable(o_energy) && $stable(o_heater_drive) && $stable(o_power_enable))
        else $error("result changed while stalled");

    // Only one request is worked on at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= 3'(helc_pkg::ST_OPEN))
        else $error("status code out of range");

    // The heater is only driven while heating with no fault latched.
    a_drive_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_heater_drive |-> o_status == 3'(helc_pkg::ST_HEAT))
        else $error("heater on outside heating");

endmodule

bind heater_energy_limit_controller helc_checker u_helc_checker (.*);
